// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, codes and helpers shared by the first-fit handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  // Operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;
  localparam logic [1:0] OP_DEFRAG  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MEM    = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;
  localparam logic [1:0] ST_NO_HANDLE = 2'd3;

  // Configuration register indexes
  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_REGION_UNITS = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  handle;
    logic [10:0] length;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [10:0] move_length;
    logic        is_move;
    logic        last;
  } result_t;

  // Assemble one result beat
  function automatic result_t mk_result(input logic [1:0] status,
                                        input logic [3:0] slot,
                                        input logic [31:0] src,
                                        input logic [31:0] dst,
                                        input logic [10:0] len,
                                        input logic mv,
                                        input logic last);
    result_t r;
    r.status      = status;
    r.slot        = slot;
    r.src_address = src;
    r.dst_address = dst;
    r.move_length = len;
    r.is_move     = mv;
    r.last        = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ffha_occ_mem.sv =====
// ----------------------------------------------------------------------------
// ffha_occ_mem
// One-bit-per-unit occupancy memory: one write port, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_occ_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/first_fit_handle_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_handle_allocator_unit
// First-fit unit allocator with a handle table and block compaction.
//
//  channel   signals                        beat taken when
//  command   start, busy, cmd               start & !busy at clk edge
//  result    valid, result                  valid (one cycle, no stall)
//  config    cfg_we, cfg_index, cfg_data    cfg_we at clk edge
//
// After reset a clearing pass writes every occupancy unit with busy high.
// Alloc streams the occupancy memory at one unit per cycle; grow-realloc
// first releases the old block, then searches, and restores the old marks
// if the search fails. Free and shrink clear the released units. Defrag
// scans the handle table to pick each block, clears its old marks, slides
// the target down over free units and sets the new marks. Results cannot
// be stalled; each beat is valid for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_handle_allocator_unit #(
  parameter int MEM_UNITS    = 1024,
  parameter int HANDLE_SLOTS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire ffha_pkg::cmd_t cmd,
  output logic                valid,
  output ffha_pkg::result_t   result,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [31:0]    cfg_data
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam int SW = (HANDLE_SLOTS > 1) ? $clog2(HANDLE_SLOTS) : 1;

  // state codes
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MARK  = 4'd2;
  localparam logic [3:0] S_FITGO = 4'd3;
  localparam logic [3:0] S_FIT   = 4'd4;
  localparam logic [3:0] S_EMIT  = 4'd5;
  localparam logic [3:0] S_DSEL  = 4'd6;
  localparam logic [3:0] S_DRD   = 4'd7;
  localparam logic [3:0] S_DEV   = 4'd8;
  localparam logic [3:0] S_DPICK = 4'd9;
  localparam logic [3:0] S_WALK  = 4'd10;
  localparam logic [3:0] S_WEV   = 4'd11;
  localparam logic [3:0] S_WDONE = 4'd12;

  logic [3:0] state;

  // configuration
  logic [31:0] base_address;
  logic [10:0] region_units;
  logic [CW-1:0] lim;

  // handle table
  logic          slot_valid  [HANDLE_SLOTS];
  logic [AW-1:0] slot_offset [HANDLE_SLOTS];
  logic [10:0]   slot_length [HANDLE_SLOTS];

  // working registers
  logic [1:0]    mode;
  logic [SW-1:0] cur;
  logic [10:0]   len_r;
  logic [AW-1:0] old_off;
  logic [10:0]   old_len;
  logic [CW-1:0] mark_addr;
  logic [CW-1:0] mark_cnt;
  logic          mark_val;
  logic [3:0]    mark_ret;
  logic [CW-1:0] fa;
  logic          rv;
  logic [CW-1:0] ri;
  logic [CW-1:0] run;
  ffha_pkg::result_t res;
  logic [3:0]    emit_ret;
  logic [SW:0]   s;
  logic [CW-1:0] best;
  logic          pick_ok;
  logic [SW:0]   mv_cnt;
  logic [AW-1:0] np;
  logic [CW-1:0] clr;

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  ffha_occ_mem #(.DEPTH(MEM_UNITS), .AW(AW)) u_occ (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // handle table read select
  logic [SW-1:0] hidx;
  logic [SW-1:0] tidx;
  logic          tbl_valid;
  logic [AW-1:0] tbl_off;
  logic [10:0]   tbl_len;
  logic          hok;

  assign hidx = SW'(cmd.handle);
  always_comb begin
    if (state == S_IDLE) begin
      tidx = hidx;
    end else if (state == S_DRD || state == S_DEV) begin
      tidx = s[SW-1:0];
    end else begin
      tidx = cur;
    end
  end
  assign tbl_valid = slot_valid[tidx];
  assign tbl_off   = slot_offset[tidx];
  assign tbl_len   = slot_length[tidx];
  assign hok = (32'(cmd.handle) < HANDLE_SLOTS) && tbl_valid;

  // lowest free handle
  logic          free_ok;
  logic [SW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = HANDLE_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // usable units and fit terms
  logic [CW-1:0] len_c;
  logic [CW-1:0] need;
  logic [CW-1:0] run_inc;
  logic [AW-1:0] where;
  assign lim = (CW'(region_units) > CW'(MEM_UNITS)) ? CW'(MEM_UNITS) : CW'(region_units);
  assign len_c   = CW'(cmd.length);
  assign need    = (len_r == 11'd0) ? CW'(1) : CW'(len_r);
  assign run_inc = run + CW'(1);
  assign where   = AW'(ri + CW'(1) - need);

  function automatic logic [31:0] addr_of(input logic [31:0] b, input logic [AW-1:0] o);
    return b + 32'(o);
  endfunction

  // occupancy memory drive
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mark_addr[AW-1:0];
    mem_wdata = mark_val;
    mem_raddr = fa[AW-1:0];
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr[AW-1:0];
        mem_wdata = 1'b0;
      end
      S_MARK: begin
        mem_we = (mark_cnt != '0) && (mark_addr < CW'(MEM_UNITS));
      end
      S_DRD:  mem_raddr = tbl_off - AW'(1);
      S_WALK: mem_raddr = np - AW'(1);
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      region_units <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffha_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
        ffha_pkg::CFG_REGION_UNITS: region_units <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr     <= '0;
      valid   <= 1'b0;
      rv      <= 1'b0;
      pick_ok <= 1'b0;
      for (int i = 0; i < HANDLE_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      valid <= 1'b0;
      unique case (state)
        // clearing pass over the occupancy memory
        S_CLR: begin
          clr <= clr + CW'(1);
          if (clr == CW'(MEM_UNITS - 1)) begin
            state <= S_IDLE;
          end
        end

        // command decode
        S_IDLE: begin
          emit_ret <= S_IDLE;
          len_r    <= cmd.length;
          if (start) begin
            case (cmd.op)
              ffha_pkg::OP_FREE: begin
                if (!hok) begin
                  res <= ffha_pkg::mk_result(ffha_pkg::ST_BAD_FREE, cmd.handle,
                                             '0, '0, '0, 1'b0, 1'b1);
                  state <= S_EMIT;
                end else begin
                  cur              <= hidx;
                  slot_valid[hidx] <= 1'b0;
                  res <= ffha_pkg::mk_result(ffha_pkg::ST_OK, cmd.handle, '0,
                                             addr_of(base_address, tbl_off),
                                             tbl_len, 1'b0, 1'b1);
                  mark_addr <= CW'(tbl_off);
                  mark_cnt  <= CW'(tbl_len);
                  mark_val  <= 1'b0;
                  mark_ret  <= S_EMIT;
                  state     <= S_MARK;
                end
              end
              ffha_pkg::OP_DEFRAG: begin
                mv_cnt <= '0;
                state  <= S_DSEL;
              end
              default: begin
                if (cmd.op == ffha_pkg::OP_REALLOC && hok) begin
                  cur     <= hidx;
                  old_off <= tbl_off;
                  old_len <= tbl_len;
                  if (tbl_len > cmd.length) begin
                    // shrink in place, release the tail
                    slot_length[hidx] <= cmd.length;
                    res <= ffha_pkg::mk_result(ffha_pkg::ST_OK, cmd.handle, '0,
                                               addr_of(base_address, tbl_off),
                                               cmd.length, 1'b0, 1'b1);
                    mark_addr <= CW'(tbl_off) + len_c;
                    mark_cnt  <= CW'(tbl_len - cmd.length);
                    mark_val  <= 1'b0;
                    mark_ret  <= S_EMIT;
                    state     <= S_MARK;
                  end else if (len_c > lim) begin
                    res <= ffha_pkg::mk_result(ffha_pkg::ST_NO_MEM, cmd.handle,
                                               '0, '0, '0, 1'b0, 1'b1);
                    state <= S_EMIT;
                  end else begin
                    // release old marks, then search
                    mode      <= ffha_pkg::OP_REALLOC;
                    mark_addr <= CW'(tbl_off);
                    mark_cnt  <= CW'(tbl_len);
                    mark_val  <= 1'b0;
                    mark_ret  <= S_FITGO;
                    state     <= S_MARK;
                  end
                end else begin
                  // plain alloc
                  mode <= ffha_pkg::OP_ALLOC;
                  if (len_c > lim) begin
                    res <= ffha_pkg::mk_result(ffha_pkg::ST_NO_MEM, 4'd0,
                                               '0, '0, '0, 1'b0, 1'b1);
                    state <= S_EMIT;
                  end else begin
                    state <= S_FITGO;
                  end
                end
              end
            endcase
          end
        end

        // write a run of marks, one unit a cycle
        S_MARK: begin
          if (mark_cnt == '0) begin
            state <= mark_ret;
          end else begin
            mark_addr <= mark_addr + CW'(1);
            mark_cnt  <= mark_cnt - CW'(1);
          end
        end

        S_FITGO: begin
          fa    <= '0;
          rv    <= 1'b0;
          run   <= '0;
          state <= S_FIT;
        end

        // streaming first-fit scan
        S_FIT: begin
          rv <= (fa < lim);
          ri <= fa;
          if (fa < lim) begin
            fa <= fa + CW'(1);
          end
          if (rv) begin
            run <= mem_rdata ? '0 : run_inc;
          end
          if (rv && !mem_rdata && run_inc >= need) begin
            if (mode == ffha_pkg::OP_ALLOC) begin
              if (!free_ok) begin
                res <= ffha_pkg::mk_result(ffha_pkg::ST_NO_HANDLE, 4'd0,
                                           '0, '0, '0, 1'b0, 1'b1);
                state <= S_EMIT;
              end else begin
                cur                   <= free_idx;
                slot_valid[free_idx]  <= 1'b1;
                slot_offset[free_idx] <= where;
                slot_length[free_idx] <= len_r;
                res <= ffha_pkg::mk_result(ffha_pkg::ST_OK, 4'(free_idx), '0,
                                           addr_of(base_address, where),
                                           len_r, 1'b0, 1'b1);
                mark_addr <= CW'(where);
                mark_cnt  <= CW'(len_r);
                mark_val  <= 1'b1;
                mark_ret  <= S_EMIT;
                state     <= S_MARK;
              end
            end else begin
              slot_offset[cur] <= where;
              slot_length[cur] <= len_r;
              res <= ffha_pkg::mk_result(ffha_pkg::ST_OK, 4'(cur),
                                         addr_of(base_address, old_off),
                                         addr_of(base_address, where),
                                         old_len, where != old_off, 1'b1);
              mark_addr <= CW'(where);
              mark_cnt  <= CW'(len_r);
              mark_val  <= 1'b1;
              mark_ret  <= S_EMIT;
              state     <= S_MARK;
            end
          end else if (!rv && !(fa < lim)) begin
            // scan exhausted
            if (mode == ffha_pkg::OP_ALLOC) begin
              res <= ffha_pkg::mk_result(ffha_pkg::ST_NO_MEM, 4'd0,
                                         '0, '0, '0, 1'b0, 1'b1);
              state <= S_EMIT;
            end else begin
              // restore the old marks
              res <= ffha_pkg::mk_result(ffha_pkg::ST_NO_MEM, 4'(cur),
                                         '0, '0, '0, 1'b0, 1'b1);
              mark_addr <= CW'(old_off);
              mark_cnt  <= CW'(old_len);
              mark_val  <= 1'b1;
              mark_ret  <= S_EMIT;
              state     <= S_MARK;
            end
          end
        end

        S_EMIT: begin
          valid  <= 1'b1;
          result <= res;
          state  <= emit_ret;
        end

        // defrag: start a pick pass or close
        S_DSEL: begin
          emit_ret <= S_IDLE;
          if (mv_cnt == (SW + 1)'(HANDLE_SLOTS)) begin
            res   <= ffha_pkg::mk_result(ffha_pkg::ST_OK, 4'd0, '0, '0, '0, 1'b0, 1'b1);
            state <= S_EMIT;
          end else begin
            s       <= '0;
            best    <= lim;
            pick_ok <= 1'b0;
            state   <= S_DRD;
          end
        end

        // candidate test, reads the unit below the block
        S_DRD: begin
          if (s == (SW + 1)'(HANDLE_SLOTS)) begin
            state <= S_DPICK;
          end else if (tbl_valid && CW'(tbl_off) < best && tbl_off != '0) begin
            state <= S_DEV;
          end else begin
            s <= s + (SW + 1)'(1);
          end
        end

        S_DEV: begin
          if (!mem_rdata) begin
            best    <= CW'(tbl_off);
            cur     <= s[SW-1:0];
            pick_ok <= 1'b1;
          end
          s     <= s + (SW + 1)'(1);
          state <= S_DRD;
        end

        S_DPICK: begin
          if (!pick_ok) begin
            res   <= ffha_pkg::mk_result(ffha_pkg::ST_OK, 4'd0, '0, '0, '0, 1'b0, 1'b1);
            state <= S_EMIT;
          end else begin
            old_off   <= tbl_off;
            old_len   <= tbl_len;
            np        <= tbl_off;
            mark_addr <= CW'(tbl_off);
            mark_cnt  <= CW'(tbl_len);
            mark_val  <= 1'b0;
            mark_ret  <= S_WALK;
            state     <= S_MARK;
          end
        end

        // slide target down over free units
        S_WALK: begin
          state <= (np == '0) ? S_WDONE : S_WEV;
        end

        S_WEV: begin
          if (!mem_rdata) begin
            np    <= np - AW'(1);
            state <= S_WALK;
          end else begin
            state <= S_WDONE;
          end
        end

        S_WDONE: begin
          slot_offset[cur] <= np;
          res <= ffha_pkg::mk_result(ffha_pkg::ST_OK, 4'(cur),
                                     addr_of(base_address, old_off),
                                     addr_of(base_address, np),
                                     old_len, 1'b1, 1'b0);
          mv_cnt    <= mv_cnt + (SW + 1)'(1);
          emit_ret  <= S_DSEL;
          mark_addr <= CW'(np);
          mark_cnt  <= CW'(old_len);
          mark_val  <= 1'b1;
          mark_ret  <= S_EMIT;
          state     <= S_MARK;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_first_fit_handle_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_handle_allocator_unit
// Drives alloc, free, realloc and defrag commands with random gaps, keeps a
// behavioral copy of the occupancy map and handle table, and checks every
// result beat against the predicted results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_handle_allocator_unit;

  localparam int UNITS = 1024;
  localparam int SLOTS = 16;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  ffha_pkg::cmd_t    cmd = '0;
  logic              valid;
  ffha_pkg::result_t result;
  logic              cfg_we = 1'b0;
  logic              cfg_index = ffha_pkg::CFG_BASE_ADDRESS;
  logic [31:0]       cfg_data = '0;

  first_fit_handle_allocator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .valid(valid), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic        occ_map [UNITS];
  logic        hv [SLOTS];
  logic [10:0] hoff [SLOTS];
  logic [10:0] hlen [SLOTS];
  logic [31:0] base_q;
  logic [10:0] region_q;

  ffha_pkg::cmd_t    cmd_queue[$];
  ffha_pkg::result_t expected_results[$];
  int      errors = 0;
  int      beats_seen = 0;
  int      moves_seen = 0;
  int      cmds_sent = 0;

  task automatic report(input string what);
    errors++;
    $display("ERROR t=%0t: %s", $time, what);
  endtask

  function automatic int units_limit();
    return (region_q > UNITS) ? UNITS : int'(region_q);
  endfunction

  function automatic void mark_run(input int off, input int len, input logic v);
    for (int i = 0; i < len; i++)
      if (off + i < UNITS) occ_map[off + i] = v;
  endfunction

  function automatic bit find_run(input int len, output int where);
    int lim, need, run;
    lim = units_limit();
    need = (len == 0) ? 1 : len;
    run = 0;
    where = 0;
    if (len > lim) return 0;
    for (int i = 0; i < lim; i++) begin
      if (occ_map[i]) run = 0;
      else begin
        run++;
        if (run >= need) begin
          where = i + 1 - need;
          return 1;
        end
      end
    end
    return 0;
  endfunction

  function automatic ffha_pkg::result_t beat(input logic [1:0] st, input int s,
                                   input logic [31:0] src, input logic [31:0] dst,
                                   input int len, input logic mv, input logic lst);
    ffha_pkg::result_t r;
    r.status = st; r.slot = 4'(s); r.src_address = src; r.dst_address = dst;
    r.move_length = 11'(len); r.is_move = mv; r.last = lst;
    return r;
  endfunction

  function automatic void predict_alloc(input int len);
    int off, h;
    h = -1;
    if (!find_run(len, off)) begin
      expected_results.push_back(beat(ffha_pkg::ST_NO_MEM, 0, 0, 0, 0, 0, 1));
      return;
    end
    for (int s = SLOTS - 1; s >= 0; s--) if (!hv[s]) h = s;
    if (h < 0) begin
      expected_results.push_back(beat(ffha_pkg::ST_NO_HANDLE, 0, 0, 0, 0, 0, 1));
      return;
    end
    mark_run(off, len, 1);
    hv[h] = 1; hoff[h] = 11'(off); hlen[h] = 11'(len);
    expected_results.push_back(beat(ffha_pkg::ST_OK, h, 0, base_q + off, len, 0, 1));
  endfunction

  // Work out the result beats of one command and update the state
  function automatic void predict_cmd(input ffha_pkg::cmd_t c);
    int h, len, off, old, nw, lim, best, pick, np;
    h = c.handle;
    len = c.length;
    case (c.op)
      ffha_pkg::OP_ALLOC: predict_alloc(len);
      ffha_pkg::OP_FREE: begin
        if (!hv[h])
          expected_results.push_back(beat(ffha_pkg::ST_BAD_FREE, h, 0, 0, 0, 0, 1));
        else begin
          mark_run(hoff[h], hlen[h], 0);
          hv[h] = 0;
          expected_results.push_back(beat(ffha_pkg::ST_OK, h, 0, base_q + hoff[h],
                                          hlen[h], 0, 1));
        end
      end
      ffha_pkg::OP_REALLOC: begin
        if (!hv[h]) predict_alloc(len);
        else begin
          off = hoff[h];
          old = hlen[h];
          if (old > len) begin
            mark_run(off + len, old - len, 0);
            hlen[h] = 11'(len);
            expected_results.push_back(beat(ffha_pkg::ST_OK, h, 0, base_q + off,
                                            len, 0, 1));
          end else begin
            mark_run(off, old, 0);
            if (!find_run(len, nw)) begin
              mark_run(off, old, 1);
              expected_results.push_back(beat(ffha_pkg::ST_NO_MEM, h, 0, 0, 0, 0, 1));
            end else begin
              mark_run(nw, len, 1);
              hoff[h] = 11'(nw); hlen[h] = 11'(len);
              expected_results.push_back(beat(ffha_pkg::ST_OK, h, base_q + off,
                                              base_q + nw, old, nw != off, 1));
            end
          end
        end
      end
      default: begin
        lim = units_limit();
        for (int m = 0; m < SLOTS; m++) begin
          best = lim;
          pick = -1;
          for (int s = 0; s < SLOTS; s++)
            if (hv[s] && hoff[s] < best && hoff[s] > 0 && !occ_map[hoff[s] - 1]) begin
              best = hoff[s];
              pick = s;
            end
          if (pick < 0) break;
          off = hoff[pick];
          len = hlen[pick];
          mark_run(off, len, 0);
          np = off;
          while (np > 0 && !occ_map[np - 1]) np--;
          mark_run(np, len, 1);
          hoff[pick] = 11'(np);
          expected_results.push_back(beat(ffha_pkg::ST_OK, pick, base_q + off,
                                          base_q + np, len, 1, 0));
        end
        expected_results.push_back(beat(ffha_pkg::ST_OK, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endfunction

  // Driver: one command beat per handshake, random gap before each
  int  gap_left = 0;
  bit  hold_drain = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_cmd(cmd);
        cmds_sent++;
        void'(cmd_queue.pop_front());
        gap_left <= $urandom_range(0, 9);
        if (gap_left == 0 && cmd_queue.size() > 0 && $urandom_range(0, 9) != 0 &&
            !hold_drain) begin
          cmd <= cmd_queue[0];
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (cmd_queue.size() > 0 && !hold_drain) begin
          start <= 1'b1;
          cmd <= cmd_queue[0];
        end
      end
    end
  end

  // Monitor: every valid cycle is one result beat
  always @(posedge clk) begin
    ffha_pkg::result_t exp_r;
    if (!rst && valid) begin
      beats_seen++;
      if (result.is_move) moves_seen++;
      if (expected_results.size() == 0)
        report($sformatf("unexpected result beat %p", result));
      else begin
        exp_r = expected_results.pop_front();
        if (result.status !== exp_r.status)
          report($sformatf("status %0d exp %0d", result.status, exp_r.status));
        if (result.slot !== exp_r.slot)
          report($sformatf("slot %0d exp %0d", result.slot, exp_r.slot));
        if (result.src_address !== exp_r.src_address)
          report($sformatf("src %h exp %h", result.src_address, exp_r.src_address));
        if (result.dst_address !== exp_r.dst_address)
          report($sformatf("dst %h exp %h", result.dst_address, exp_r.dst_address));
        if (result.move_length !== exp_r.move_length)
          report($sformatf("move_length %0d exp %0d", result.move_length,
                           exp_r.move_length));
        if (result.is_move !== exp_r.is_move)
          report($sformatf("is_move %0b exp %0b", result.is_move, exp_r.is_move));
        if (result.last !== exp_r.last)
          report($sformatf("last %0b exp %0b", result.last, exp_r.last));
      end
    end
  end

  function automatic ffha_pkg::cmd_t mk_cmd(input logic [1:0] op, input int h,
                                            input int len);
    ffha_pkg::cmd_t c;
    c.op = op; c.handle = 4'(h); c.length = 11'(len);
    return c;
  endfunction

  // Wait for all queued commands to be taken and all results to arrive
  task automatic drain();
    while (cmd_queue.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffha_pkg::CFG_BASE_ADDRESS) base_q = val;
    else region_q = val[10:0];
  endtask

  function automatic ffha_pkg::cmd_t random_cmd(input int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return mk_cmd(ffha_pkg::OP_ALLOC, $urandom_range(0, 15),
                              ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, lim / 6));
    if (r < 65) return mk_cmd(ffha_pkg::OP_FREE, $urandom_range(0, 15),
                              $urandom_range(0, 2047));
    if (r < 90) return mk_cmd(ffha_pkg::OP_REALLOC, $urandom_range(0, 15),
                              ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, lim / 5));
    return mk_cmd(ffha_pkg::OP_DEFRAG, $urandom_range(0, 15), $urandom_range(0, 2047));
  endfunction

  initial begin
    for (int i = 0; i < UNITS; i++) occ_map[i] = 0;
    for (int s = 0; s < SLOTS; s++) begin
      hv[s] = 0; hoff[s] = '0; hlen[s] = '0;
    end
    base_q = '0;
    region_q = 11'd1024;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: edges of length, handle exhaustion, realloc cases, defrag
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_FREE, 15, 0));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_ALLOC, 0, 0));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_ALLOC, 0, 1024));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_ALLOC, 0, 1));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_FREE, 1, 0));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_ALLOC, 0, 2047));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_REALLOC, 0, 0));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_FREE, 0, 0));
    for (int i = 0; i < 16; i++) cmd_queue.push_back(mk_cmd(ffha_pkg::OP_ALLOC, 0, 3));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_ALLOC, 0, 2));
    drain();

    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_FREE, 2, 0));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_FREE, 5, 0));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_REALLOC, 7, 1));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_REALLOC, 8, 6));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_REALLOC, 9, 1000));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_REALLOC, 10, 1024));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_DEFRAG, 0, 0));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_REALLOC, 2, 5));
    cmd_queue.push_back(mk_cmd(ffha_pkg::OP_DEFRAG, 15, 2047));
    drain();

    // Random phases over several region settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_cfg(ffha_pkg::CFG_BASE_ADDRESS, 32'hFFFF_FFF0);
          write_cfg(ffha_pkg::CFG_REGION_UNITS, 64);
        end
        1: begin
          write_cfg(ffha_pkg::CFG_BASE_ADDRESS, $urandom);
          write_cfg(ffha_pkg::CFG_REGION_UNITS, 1);
        end
        2: begin
          write_cfg(ffha_pkg::CFG_BASE_ADDRESS, 32'h0);
          write_cfg(ffha_pkg::CFG_REGION_UNITS, 2047);
        end
        3: begin
          write_cfg(ffha_pkg::CFG_BASE_ADDRESS, $urandom);
          write_cfg(ffha_pkg::CFG_REGION_UNITS, 100);
        end
        default: begin
          write_cfg(ffha_pkg::CFG_BASE_ADDRESS, 32'hFFFF_FFFF);
          write_cfg(ffha_pkg::CFG_REGION_UNITS, 1024);
        end
      endcase
      for (int i = 0; i < 35; i++) begin
        cmd_queue.push_back(random_cmd((region_q > UNITS) ? UNITS : region_q));
        if (i == 20) begin
          // hold the sender until every expected beat is back
          while (cmd_queue.size() > 0 || start) @(posedge clk);
          hold_drain = 1;
          while (expected_results.size() > 0) @(posedge clk);
          hold_drain = 0;
        end
      end
      drain();
    end

    $display("Covered %0d commands, %0d result beats, %0d move beats, 5 region settings.",
             cmds_sent, beats_seen, moves_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_occ_mem.sv
rtl/first_fit_handle_allocator_unit.sv
tb/sv/tb_first_fit_handle_allocator_unit.sv
